// File: hdl/bmf_pkg.sv
// Shared types, constants and codes for the box mean filter.
`default_nettype none
package bmf_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_RADIUS_DEF = 7;
  localparam int unsigned MAX_HEIGHT     = 4096;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned VERT_W  = 12;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned COL_FW  = 10;
  localparam int unsigned ROW_FW  = 12;
  localparam int unsigned RAD_W   = 3;
  localparam int unsigned FW_W    = 11;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;
  localparam logic [FW_W-1:0]  FWIDTH_RST = 11'd640;
  localparam logic [FH_W-1:0]  FHEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [CH_W-1:0] pixel_ch2;
    logic [CH_W-1:0] pixel_ch1;
    logic [CH_W-1:0] pixel_ch0;
  } pix_t;

  typedef struct packed {
    logic              frame_last;
    logic [ROW_FW-1:0] center_row;
    logic [COL_FW-1:0] center_col;
    logic [CH_W-1:0]   mean_ch2;
    logic [CH_W-1:0]   mean_ch1;
    logic [CH_W-1:0]   mean_ch0;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REM,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic clr;      // clear sweep write of column sums
    logic rd;       // read column sum and line entry
    logic upd;      // write back, update window sum, load divider
    logic div_step; // one quotient bit
    logic wr_en;    // radius nonzero: line store and column sums live
    logic y0;       // first row
    logic x0;       // first column
    logic drop_en;  // oldest row leaves the column sum
    logic sub_en;   // oldest column leaves the window sum
  } lane_ctl_t;

endpackage
`default_nettype wire

// File: hdl/bmf_lane.sv
// One color channel: line store, column sums, window sum and rounding divider.
`default_nettype none
module bmf_lane
  import bmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int unsigned CW   = $clog2(MAX_WIDTH),
  localparam int unsigned LINES = 2 * MAX_RADIUS,
  localparam int unsigned LAW  = $clog2(LINES * MAX_WIDTH),
  localparam int unsigned RING = 2 * MAX_RADIUS + 1,
  localparam int unsigned RIW  = $clog2(RING),
  localparam int unsigned NW   = $clog2(RING * RING + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lane_ctl_t       ctl_i,
  input  wire logic [CW-1:0]   col_addr_i,
  input  wire logic [LAW-1:0]  line_addr_i,
  input  wire logic [RIW-1:0]  ring_at_i,
  input  wire logic [NW-1:0]   n_i,
  input  wire logic [CH_W-1:0] pix_i,
  output logic      [CH_W-1:0] mean_o
);

  logic [VERT_W-1:0] col_mem [MAX_WIDTH];
  logic [CH_W-1:0]   row_mem [LINES * MAX_WIDTH];
  logic [VERT_W-1:0] col_rd_q;
  logic [CH_W-1:0]   row_rd_q;
  logic [VERT_W-1:0] ring_q [RING];
  logic [SUM_W-1:0]  ws_q, ws_d;
  logic [VERT_W-1:0] vert, drop, col_wr;
  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [NW-1:0]     rem_q, rem_d;
  logic [NW:0]       trial, twice;
  logic              up;
  logic [SUM_W:0]    qr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      col_rd_q <= col_mem[col_addr_i];
      row_rd_q <= row_mem[line_addr_i];
    end
    if (ctl_i.clr) begin
      col_mem[col_addr_i] <= '0;
    end else if (ctl_i.upd) begin
      col_mem[col_addr_i] <= col_wr;
    end
    if (ctl_i.upd && ctl_i.wr_en) begin
      row_mem[line_addr_i] <= pix_i;
    end
  end

  always_comb begin
    vert   = (ctl_i.y0 ? '0 : col_rd_q) + VERT_W'(pix_i);
    drop   = ctl_i.drop_en ? VERT_W'(row_rd_q) : '0;
    col_wr = ctl_i.wr_en ? VERT_W'(vert - drop) : '0;
    ws_d   = (ctl_i.x0 ? '0 : ws_q) - (ctl_i.sub_en ? SUM_W'(ring_q[ring_at_i]) : '0)
             + SUM_W'(vert);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
      for (int i = 0; i < RING; i++) ring_q[i] <= '0;
    end else if (ctl_i.upd) begin
      ws_q <= ws_d;
      ring_q[ring_at_i] <= vert;
    end
  end

  // restoring divide, one quotient bit per step
  always_comb begin
    trial = {rem_q, dq_q[SUM_W-1]};
    if (trial >= {1'b0, n_i}) begin
      rem_d = NW'(trial - {1'b0, n_i});
      dq_d  = {dq_q[SUM_W-2:0], 1'b1};
    end else begin
      rem_d = trial[NW-1:0];
      dq_d  = {dq_q[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      dq_q  <= ws_d;
      rem_q <= '0;
    end else if (ctl_i.div_step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  // round half to even, then saturate
  always_comb begin
    twice  = {rem_q, 1'b0};
    up     = (twice > {1'b0, n_i}) || ((twice == {1'b0, n_i}) && dq_q[0]);
    qr     = {1'b0, dq_q} + (SUM_W + 1)'(up);
    mean_o = (qr > (SUM_W + 1)'(255)) ? 8'd255 : qr[CH_W-1:0];
  end

endmodule
`default_nettype wire

// File: hdl/bmf_ctl.sv
// Sequencer: position counters, clear sweep, address remainders, lane strobes.
`default_nettype none
module bmf_ctl
  import bmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int unsigned CW   = $clog2(MAX_WIDTH),
  localparam int unsigned LINES = 2 * MAX_RADIUS,
  localparam int unsigned LAW  = $clog2(LINES * MAX_WIDTH),
  localparam int unsigned RING = 2 * MAX_RADIUS + 1,
  localparam int unsigned RIW  = $clog2(RING),
  localparam int unsigned NW   = $clog2(RING * RING + 1),
  localparam int unsigned RW   = $clog2(MAX_RADIUS + 1),
  localparam int unsigned SW   = $clog2(RING + 1),
  localparam int unsigned MW   = (CW > ROW_FW) ? CW : ROW_FW,
  localparam int unsigned STW  = $clog2(((MW > SUM_W) ? MW : SUM_W) + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [RAD_W-1:0] radius_i,
  input  wire logic [FW_W-1:0]  fwidth_i,
  input  wire logic [FH_W-1:0]  fheight_i,
  input  wire logic             can_push_i,
  output logic                  push_o,
  output lane_ctl_t             lane_ctl_o,
  output logic      [CW-1:0]    col_addr_o,
  output logic      [LAW-1:0]   line_addr_o,
  output logic      [RIW-1:0]   ring_at_o,
  output logic      [NW-1:0]    n_o,
  output logic      [COL_FW-1:0] center_col_o,
  output logic      [ROW_FW-1:0] center_row_o,
  output logic                  last_o
);

  ctl_state_e        state_q, state_d;
  logic [CW-1:0]     clr_q;
  logic [STW-1:0]    step_q;
  logic [CW-1:0]     col_q, x_q;
  logic [ROW_FW-1:0] row_q, y_q;
  logic [RW-1:0]     r_q, r_eff;
  logic [SW-1:0]     side_q, two_r, dy;
  logic [NW-1:0]     n_q;
  logic              wlast_q, hlast_q;
  logic [MW-1:0]     sx_q, sy_q;
  logic [SW-1:0]     remx_q, remy_q, remx_d, remy_d;
  logic [SW:0]       tx, ty;
  logic              accept, emit;
  logic              end_col, end_row;
  int unsigned       w_eff, h_eff;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    r_eff = (int'(radius_i) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_i);
    w_eff = (fwidth_i == '0) ? 1 : ((int'(fwidth_i) > MAX_WIDTH) ? MAX_WIDTH : int'(fwidth_i));
    h_eff = (fheight_i == '0) ? 1 :
            ((int'(fheight_i) > MAX_HEIGHT) ? MAX_HEIGHT : int'(fheight_i));
    end_col = (int'(col_q) + 1) >= w_eff;
    end_row = (int'(row_q) + 1) >= h_eff;
  end

  always_comb begin
    two_r = SW'({r_q, 1'b0});
    dy    = (r_q == '0) ? SW'(1) : two_r;
    tx    = {remx_q, sx_q[MW-1]};
    ty    = {remy_q, sy_q[MW-1]};
    remx_d = (tx >= {1'b0, side_q}) ? SW'(tx - {1'b0, side_q}) : tx[SW-1:0];
    remy_d = (ty >= {1'b0, dy}) ? SW'(ty - {1'b0, dy}) : ty[SW-1:0];
    emit  = (int'(x_q) >= int'(two_r)) && (int'(y_q) >= int'(two_r));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (int'(clr_q) == MAX_WIDTH - 1) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_REM;
      ST_REM:    if (int'(step_q) == MW - 1) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = emit ? ST_DIV : ST_IDLE;
      ST_DIV:    if (int'(step_q) == SUM_W - 1) state_d = ST_EMIT;
      ST_EMIT:   if (can_push_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    push_o     = (state_q == ST_EMIT) && can_push_i;
    lane_ctl_o = '0;
    lane_ctl_o.clr      = (state_q == ST_CLEAR);
    lane_ctl_o.rd       = (state_q == ST_READ);
    lane_ctl_o.upd      = (state_q == ST_UPDATE);
    lane_ctl_o.div_step = (state_q == ST_DIV);
    lane_ctl_o.wr_en    = (r_q != '0);
    lane_ctl_o.y0       = (y_q == '0);
    lane_ctl_o.x0       = (x_q == '0);
    lane_ctl_o.drop_en  = int'(y_q) >= int'(two_r);
    lane_ctl_o.sub_en   = int'(x_q) >= int'(side_q);
    col_addr_o  = (state_q == ST_CLEAR) ? clr_q : x_q;
    line_addr_o = LAW'(remy_q) * LAW'(MAX_WIDTH) + LAW'(x_q);
    ring_at_o   = RIW'(remx_q);
    n_o         = n_q;
    center_col_o = COL_FW'(x_q - CW'(r_q));
    center_row_o = ROW_FW'(y_q - ROW_FW'(r_q));
    last_o       = wlast_q && hlast_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
      if (state_q == ST_REM || state_q == ST_DIV) begin
        step_q <= (state_d == state_q) ? step_q + STW'(1) : '0;
      end else begin
        step_q <= '0;
      end
      if (accept) begin
        if (end_col) begin
          col_q <= '0;
          row_q <= end_row ? '0 : row_q + ROW_FW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= col_q;
      y_q     <= row_q;
      r_q     <= r_eff;
      side_q  <= SW'({r_eff, 1'b1});
      n_q     <= NW'((2 * int'(r_eff) + 1) * (2 * int'(r_eff) + 1));
      wlast_q <= end_col;
      hlast_q <= end_row;
      sx_q    <= MW'(col_q);
      sy_q    <= MW'(row_q);
      remx_q  <= '0;
      remy_q  <= '0;
    end else if (state_q == ST_REM) begin
      sx_q   <= {sx_q[MW-2:0], 1'b0};
      sy_q   <= {sy_q[MW-2:0], 1'b0};
      remx_q <= remx_d;
      remy_q <= remy_d;
    end
  end

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o) else $error("input taken during clear");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("second word taken while busy");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> can_push_i) else $error("push into full output");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> int'(step_q) < SUM_W) else $error("divider overrun");

endmodule
`default_nettype wire

// File: hdl/bmf_merge.sv
// Merge stage: joins lane means and position into the registered result word.
`default_nettype none
module bmf_merge
  import bmf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [CH_W-1:0]   mean0_i,
  input  wire logic [CH_W-1:0]   mean1_i,
  input  wire logic [CH_W-1:0]   mean2_i,
  input  wire logic [COL_FW-1:0] col_i,
  input  wire logic [ROW_FW-1:0] row_i,
  input  wire logic              last_i,
  output logic                   can_push_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output res_t                   out_data_o
);

  logic valid_q;
  res_t data_q;

  assign can_push_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q.mean_ch0   <= mean0_i;
      data_q.mean_ch1   <= mean1_i;
      data_q.mean_ch2   <= mean2_i;
      data_q.center_col <= col_i;
      data_q.center_row <= row_i;
      data_q.frame_last <= last_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/box_mean_filter_integral_core.sv
// Box mean filter top: config registers, sequencer, three channel lanes, merge.
// Path: a word with a result passes the 12-step address remainder, read,
//   update, 16-step rounding divide and merge register, in that order.
// Input: a new pixel is taken only once the last one is through, so the
//   bit-serial remainder and divider bound the pixel rate.
// Reset: registers go to radius 1, 640 x 480; a sweep over every column address
//   then zeroes the column sums, with input held off. Line store is not cleared.
`default_nettype none
module box_mean_filter_integral_core
  import bmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pix_t                  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output res_t                       out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RING = 2 * MAX_RADIUS + 1;
  localparam int unsigned LAW  = $clog2(2 * MAX_RADIUS * MAX_WIDTH);
  localparam int unsigned RIW  = $clog2(RING);
  localparam int unsigned NW   = $clog2(RING * RING + 1);

  logic [RAD_W-1:0] radius_q;
  logic [FW_W-1:0]  fwidth_q;
  logic [FH_W-1:0]  fheight_q;
  pix_t             pix_q;

  lane_ctl_t         lane_ctl;
  logic [CW-1:0]     col_addr;
  logic [LAW-1:0]    line_addr;
  logic [RIW-1:0]    ring_at;
  logic [NW-1:0]     n;
  logic [COL_FW-1:0] center_col;
  logic [ROW_FW-1:0] center_row;
  logic              last, push, can_push;
  logic [CH_W-1:0]   mean0, mean1, mean2;

  // config writes are always taken; unknown index is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      fwidth_q  <= FWIDTH_RST;
      fheight_q <= FHEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RADIUS:       radius_q  <= cfg_data_i[RAD_W-1:0];
        REG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: fheight_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the accepted pixel for the lanes
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) pix_q <= in_data_i;
  end

  bmf_ctl #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_ctl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .radius_i(radius_q), .fwidth_i(fwidth_q), .fheight_i(fheight_q),
    .can_push_i(can_push), .push_o(push), .lane_ctl_o(lane_ctl),
    .col_addr_o(col_addr), .line_addr_o(line_addr), .ring_at_o(ring_at), .n_o(n),
    .center_col_o(center_col), .center_row_o(center_row), .last_o(last)
  );

  // one lane per color channel
  bmf_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_lane0 (
    .clk_i, .rst_ni, .ctl_i(lane_ctl), .col_addr_i(col_addr), .line_addr_i(line_addr),
    .ring_at_i(ring_at), .n_i(n), .pix_i(pix_q.pixel_ch0), .mean_o(mean0)
  );
  bmf_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_lane1 (
    .clk_i, .rst_ni, .ctl_i(lane_ctl), .col_addr_i(col_addr), .line_addr_i(line_addr),
    .ring_at_i(ring_at), .n_i(n), .pix_i(pix_q.pixel_ch1), .mean_o(mean1)
  );
  bmf_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_lane2 (
    .clk_i, .rst_ni, .ctl_i(lane_ctl), .col_addr_i(col_addr), .line_addr_i(line_addr),
    .ring_at_i(ring_at), .n_i(n), .pix_i(pix_q.pixel_ch2), .mean_o(mean2)
  );

  bmf_merge u_merge (
    .clk_i, .rst_ni, .push_i(push),
    .mean0_i(mean0), .mean1_i(mean1), .mean2_i(mean2),
    .col_i(center_col), .row_i(center_row), .last_i(last),
    .can_push_o(can_push), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
